[hw/rtl/dms_pkg.sv]
// dms_pkg: types and constants shared by the drift mobility step unit
// depends on nothing; used by dms_ctrl, dms_dp and drift_mobility_step_unit
package dms_pkg;

    localparam logic [1:0] CMD_TICK     = 2'd0;
    localparam logic [1:0] CMD_LOAD_POS = 2'd1;
    localparam logic [1:0] CMD_LOAD_BASE = 2'd2;
    localparam logic [1:0] CMD_LOAD_CUR = 2'd3;

    localparam logic [2:0] REG_ALPHA  = 3'd0;
    localparam logic [2:0] REG_TICK   = 3'd1;
    localparam logic [2:0] REG_BOUNDS = 3'd2;
    localparam logic [2:0] REG_LIM_X  = 3'd3;
    localparam logic [2:0] REG_LIM_Y  = 3'd4;
    localparam logic [2:0] REG_LIM_Z  = 3'd5;
    localparam logic [2:0] REG_AMPS   = 3'd6;

    localparam int CFG_W = 48;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [15:0] noise_x;
        logic signed [15:0] noise_y;
        logic signed [15:0] noise_z;
        logic signed [31:0] load_x;
        logic signed [31:0] load_y;
        logic signed [31:0] load_z;
    } t_in;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [23:0] speed_x;
        logic signed [23:0] speed_y;
        logic signed [23:0] speed_z;
        logic [2:0]         reflected;
    } t_out;

    // datapath micro-step codes
    localparam logic [2:0] OP_LOAD  = 3'd0;
    localparam logic [2:0] OP_NOISE = 3'd1;
    localparam logic [2:0] OP_MIXA  = 3'd2;
    localparam logic [2:0] OP_MIXB  = 3'd3;
    localparam logic [2:0] OP_STEP  = 3'd4;
    localparam logic [2:0] OP_POS   = 3'd5;

    typedef struct packed {
        logic       en;
        logic [2:0] op;
        logic [1:0] axis;
        logic       capture;
        logic       clr_refl;
    } t_cmd;

endpackage

[hw/rtl/dms_ctrl.sv]
// dms_ctrl: sequencer for the drift mobility step unit
// depends on dms_pkg; issues datapath steps per axis, owns the handshake
module dms_ctrl #(
    parameter int AXES = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic [1:0]    i_command,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output dms_pkg::t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;
    localparam logic [1:0] LAST_AXIS = 2'(AXES - 1);

    logic [1:0] r_state, n_state;
    logic [2:0] r_op, n_op;
    logic [1:0] r_axis, n_axis;
    logic       r_load, n_load;
    logic       accept;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign accept      = i_in_valid && (r_state == S_IDLE);

    // next state and step counters
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_axis  = r_axis;
        n_load  = r_load;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_RUN;
                    n_axis  = 2'd0;
                    n_load  = (i_command != dms_pkg::CMD_TICK);
                    n_op    = (i_command != dms_pkg::CMD_TICK) ? dms_pkg::OP_LOAD
                                                               : dms_pkg::OP_NOISE;
                end
            end
            S_RUN: begin
                if (r_load || r_op == dms_pkg::OP_POS) begin
                    if (r_axis == LAST_AXIS) begin
                        n_state = S_OUT;
                    end else begin
                        n_axis = r_axis + 2'd1;
                        n_op   = r_load ? dms_pkg::OP_LOAD : dms_pkg::OP_NOISE;
                    end
                end else begin
                    n_op = r_op + 3'd1;
                end
            end
            S_OUT: begin
                if (!i_out_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // commands to the datapath
    always_comb begin
        o_cmd.en       = (r_state == S_RUN);
        o_cmd.op       = r_op;
        o_cmd.axis     = r_axis;
        o_cmd.capture  = accept;
        o_cmd.clr_refl = accept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= dms_pkg::OP_LOAD;
            r_axis  <= 2'd0;
            r_load  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_axis  <= n_axis;
            r_load  <= n_load;
        end
    end

endmodule

[hw/rtl/dms_dp.sv]
// dms_dp: datapath of the drift mobility step unit, one shared multiplier
// depends on dms_pkg; holds state, config registers and the request latch
module dms_dp #(
    parameter int AXES = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_index,
    input  logic [dms_pkg::CFG_W-1:0] i_cfg_data,
    input  dms_pkg::t_in          i_in_data,
    input  dms_pkg::t_cmd         i_cmd,
    output dms_pkg::t_out         o_out_data
);

    localparam logic signed [63:0] SPD_MAX = 64'sd8388607;
    localparam logic signed [63:0] SPD_MIN = -64'sd8388608;
    localparam logic signed [63:0] POS_MAX = 64'sd2147483647;
    localparam logic signed [63:0] POS_MIN = -64'sd2147483648;

    // config registers
    logic [16:0] r_alpha;
    logic [15:0] r_tick;
    logic [2:0]  r_bounds;
    logic [30:0] r_lim [3];
    logic [47:0] r_amps;

    // state
    logic signed [31:0] r_pos  [AXES];
    logic signed [23:0] r_cur  [AXES];
    logic signed [23:0] r_base [AXES];
    logic [2:0]         r_refl;

    // request latch and intermediates
    dms_pkg::t_in       r_req;
    logic signed [41:0] r_acc;
    logic signed [26:0] r_drive;

    function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
        if (v > SPD_MAX) return 24'sh7FFFFF;
        if (v < SPD_MIN) return -24'sh800000;
        return v[23:0];
    endfunction

    // per-axis selections
    logic [1:0]          ax;
    logic signed [15:0]  nz;
    logic signed [31:0]  ld;
    logic [15:0]         amp;
    logic [16:0]         a_eff;
    logic [30:0]         lim;
    logic signed [31:0]  pos_c;
    logic signed [23:0]  cur_c, base_c;

    assign ax = i_cmd.axis;
    always_comb begin
        case (ax)
            2'd0: begin nz = r_req.noise_x; ld = r_req.load_x; amp = r_amps[15:0]; end
            2'd1: begin nz = r_req.noise_y; ld = r_req.load_y; amp = r_amps[31:16]; end
            default: begin nz = r_req.noise_z; ld = r_req.load_z; amp = r_amps[47:32]; end
        endcase
        lim    = r_lim[ax];
        pos_c  = r_pos[ax];
        cur_c  = r_cur[ax];
        base_c = r_base[ax];
        a_eff  = (r_alpha > 17'd65536) ? 17'd65536 : r_alpha;
    end

    // shared multiplier operands
    logic signed [26:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [44:0] prod;
    always_comb begin
        case (i_cmd.op)
            dms_pkg::OP_NOISE: begin mul_a = 27'(nz);      mul_b = $signed({2'b0, amp}); end
            dms_pkg::OP_MIXA:  begin mul_a = 27'(cur_c);   mul_b = $signed({1'b0, a_eff}); end
            dms_pkg::OP_MIXB:  begin
                mul_a = r_drive;
                mul_b = $signed({1'b0, 17'(17'd65536 - a_eff)});
            end
            dms_pkg::OP_STEP:  begin mul_a = 27'(cur_c);   mul_b = $signed({2'b0, r_tick}); end
            default:           begin mul_a = '0;           mul_b = '0; end
        endcase
        prod = mul_a * mul_b;
    end

    // reflection on the new position
    logic signed [33:0] np, lims, refl_np;
    logic               hit;
    logic signed [23:0] step_cur;
    always_comb begin
        np   = 34'(pos_c) + 34'(r_acc >>> 16);
        lims = $signed({3'b0, lim});
        hit  = 1'b0;
        refl_np = np;
        if (r_bounds[ax]) begin
            if (ax != 2'd2) begin
                if (np > lims) begin refl_np = 2 * lims - np; hit = 1'b1; end
                else if (np < 0) begin refl_np = -np; hit = 1'b1; end
            end else begin
                if (np < -lims) begin refl_np = -2 * lims - np; hit = 1'b1; end
                else if (np > 0) begin refl_np = -np; hit = 1'b1; end
            end
        end
        step_cur = cur_c;
    end

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha  <= '0;
            r_tick   <= 16'd256;
            r_bounds <= 3'd6;
            r_lim[0] <= '0;
            r_lim[1] <= '0;
            r_lim[2] <= '0;
            r_amps   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dms_pkg::REG_ALPHA:  r_alpha  <= i_cfg_data[16:0];
                dms_pkg::REG_TICK:   r_tick   <= i_cfg_data[15:0];
                dms_pkg::REG_BOUNDS: r_bounds <= i_cfg_data[2:0];
                dms_pkg::REG_LIM_X:  r_lim[0] <= i_cfg_data[30:0];
                dms_pkg::REG_LIM_Y:  r_lim[1] <= i_cfg_data[30:0];
                dms_pkg::REG_LIM_Z:  r_lim[2] <= i_cfg_data[30:0];
                dms_pkg::REG_AMPS:   r_amps   <= i_cfg_data[47:0];
                default: ;
            endcase
        end
    end

    // request latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) r_req <= i_in_data;
    end

    // sequenced datapath steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AXES; i++) begin
                r_pos[i]  <= '0;
                r_cur[i]  <= '0;
                r_base[i] <= '0;
            end
            r_refl <= '0;
        end else begin
            if (i_cmd.clr_refl) r_refl <= '0;
            if (i_cmd.en) begin
                case (i_cmd.op)
                    dms_pkg::OP_LOAD: begin
                        case (r_req.command)
                            dms_pkg::CMD_LOAD_POS:  r_pos[ax]  <= ld;
                            dms_pkg::CMD_LOAD_BASE: r_base[ax] <= sat24(64'(ld));
                            default:                r_cur[ax]  <= sat24(64'(ld));
                        endcase
                    end
                    dms_pkg::OP_NOISE: begin
                        // drive = base + round(amp*noise / 2^7)
                        r_drive <= 27'(base_c) + 27'((prod + 45'sd64) >>> 7);
                    end
                    dms_pkg::OP_MIXA: r_acc <= 42'(prod);
                    dms_pkg::OP_MIXB: begin
                        r_cur[ax] <= sat24(64'((r_acc + 42'(prod) + 42'sd32768) >>> 16));
                    end
                    dms_pkg::OP_STEP: r_acc <= 42'(prod) + 42'sd32768;
                    dms_pkg::OP_POS: begin
                        if (refl_np > 34'(POS_MAX)) r_pos[ax] <= 32'sh7FFFFFFF;
                        else if (refl_np < 34'(POS_MIN)) r_pos[ax] <= 32'sh80000000;
                        else r_pos[ax] <= refl_np[31:0];
                        if (hit) begin
                            r_cur[ax]  <= sat24(-64'(step_cur));
                            r_base[ax] <= sat24(-64'(base_c));
                            r_refl[ax] <= 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // result fields, missing axes read as zero
    always_comb begin
        o_out_data = '0;
        o_out_data.pos_x   = r_pos[0];
        o_out_data.speed_x = r_cur[0];
        if (AXES > 1) begin
            o_out_data.pos_y   = r_pos[(AXES > 1) ? 1 : 0];
            o_out_data.speed_y = r_cur[(AXES > 1) ? 1 : 0];
        end
        if (AXES > 2) begin
            o_out_data.pos_z   = r_pos[(AXES > 2) ? 2 : 0];
            o_out_data.speed_z = r_cur[(AXES > 2) ? 2 : 0];
        end
        o_out_data.reflected = r_refl;
    end

endmodule

[hw/rtl/drift_mobility_step_unit.sv]
// drift_mobility_step_unit: top level, Gauss-Markov drift step with reflection
// a tick request runs five datapath steps per axis in turn (noise, mix A, mix B, step,
// position), the first four sharing one multiplier; a load runs one load step per axis
// a new request is stalled until the result of the last one has been taken,
// and the result holds until taken
// synchronous active-low reset: positions and speeds zero, config to defaults
module drift_mobility_step_unit #(
    parameter int AXES = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_index,
    input  logic [dms_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  dms_pkg::t_in          i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output dms_pkg::t_out         o_out_data
);

    dms_pkg::t_cmd cmd;

    dms_ctrl #(.AXES(AXES)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_command   (i_in_data.command),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    dms_dp #(.AXES(AXES)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_out_data  (o_out_data)
    );

endmodule
